// File: src/phdt_pkg.sv
package phdt_pkg;

   localparam int unsigned TableDepthDefault = 65536;
   localparam logic [31:0] HeatMax = 32'hFFFF_FFFF;

   localparam logic [1:0] CSR_DECAY_PERIOD = 2'd0;
   localparam logic [1:0] CSR_EXEC_INC     = 2'd1;
   localparam logic [1:0] CSR_WRITE_INC    = 2'd2;
   localparam logic [1:0] CSR_READ_INC     = 2'd3;

   localparam logic [31:0] DecayPeriodReset = 32'd1000;
   localparam logic [31:0] IncReset         = 32'd65536;

   // Fraction table 2^(-i/256) in Q1.16, built in Q1.32 by a loop over all entries.
   function automatic logic [16:0] frac_factor(input logic [7:0] idx);
      logic [63:0] t;
      logic [16:0] res;
      t = 64'd1 << 32;
      res = 17'd0;
      for (int i = 0; i < 256; i++) begin
         if (i == int'(idx)) begin
            res = 17'((t + 64'd32768) >> 16);
         end
         t = (t * 64'd4283353945 + (64'd1 << 31)) >> 32;
      end
      return res;
   endfunction

   function automatic logic [16:0] frac_lookup(input logic [7:0] idx);
      return frac_factor(idx);
   endfunction

endpackage

// File: src/phdt_divider.sv
// Restoring divider: 48-bit dividend by 32-bit divisor, one quotient bit per cycle,
// followed by eight more steps that produce the 8-bit fraction of the remainder.
module phdt_divider
   import phdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic        q_big,
   output logic [4:0]  q_low,
   output logic [7:0]  frac
);
   logic [47:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic        ovf_ff, ovf_in;
   logic [33:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      trial   = 34'd0;
      if (start) begin
         quot_in = dividend;
         rem_in  = 33'd0;
         dvs_in  = divisor;
         cnt_in  = 6'd56;
         run_in  = 1'b1;
         ovf_in  = 1'b0;
      end else if (run_ff) begin
         // Steps past the 48 dividend bits feed back early quotient bits.
         trial = {rem_ff, quot_ff[47]} - {2'b00, dvs_ff};
         if (!trial[33]) begin
            rem_in = trial[32:0];
         end else begin
            rem_in = {rem_ff[31:0], quot_ff[47]};
         end
         quot_in = {quot_ff[46:0], !trial[33]};
         // In the last eight steps the bit leaving the top is a high quotient bit.
         ovf_in  = ovf_ff | ((cnt_ff <= 6'd8) & quot_ff[47]);
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      ovf_ff  <= ovf_in;
   end

   // After 56 steps the low 8 bits hold the fraction and bits 47:8 the low 40 bits
   // of the whole quotient; its upper bits have been collected in the overflow flag.
   assign done  = done_ff;
   assign frac  = quot_ff[7:0];
   assign q_low = quot_ff[12:8];
   assign q_big = ovf_ff | (|quot_ff[47:13]);
endmodule

// File: src/phdt_store.sv
// Heat and stamp memories with a registered synchronous read.
module phdt_store
   import phdt_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TableDepthDefault,
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_heat,
   output logic [47:0]   rd_stamp,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_heat,
   input  logic [47:0]   wr_stamp
);
   logic [31:0] heat_mem  [TABLE_DEPTH];
   logic [47:0] stamp_mem [TABLE_DEPTH];
   logic [31:0] heat_ff;
   logic [47:0] stamp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heat_mem[wr_addr]  <= wr_heat;
         stamp_mem[wr_addr] <= wr_stamp;
      end
      heat_ff  <= heat_mem[rd_addr];
      stamp_ff <= stamp_mem[rd_addr];
   end

   assign rd_heat  = heat_ff;
   assign rd_stamp = stamp_ff;
endmodule

// File: src/page_hotness_decay_tracker_core.sv
// Page heat tracker with exponential cooling.
// A word is issued on req_page_index, req_access_kind and req_now_ms with start while
// busy is low. The page's heat cools by 2^-(elapsed/half-life), gains the increment
// of its access kind (execute over write over read), saturates at all ones, and is
// written back with the new time stamp. One result word per request appears on
// rsp_page_echo and rsp_new_heat for a single cycle, marked by rsp_valid; the
// receiver cannot stall it.
// busy stays high until the result cycle ends, so one request is in flight and a new
// one is taken only after the last result. The request passes a 12-step reduction of
// the page index to a table slot, one memory fetch, the 56-step restoring divider that
// splits the elapsed time into shift count and table index, and the multiply and add
// stages. The csr_ port writes half-life and the three increments; writing in idle
// time is a rule on the user that the block itself does not enforce. A half-life of
// zero acts as one. After reset the block sweeps both memories to zero, one entry a
// cycle, and busy stays high until all TABLE_DEPTH entries (65536 by default) are
// cleared, before the first request is taken. Requests whose page index exceeds the
// table use the index modulo TABLE_DEPTH when TABLE_DEPTH is at least 16.
module page_hotness_decay_tracker_core
   import phdt_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_page_index,
   input  logic [2:0]  req_access_kind,
   input  logic [47:0] req_now_ms,
   output logic        rsp_valid,
   output logic [15:0] rsp_page_echo,
   output logic [31:0] rsp_new_heat,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [AW:0] TableDepthW = (AW+1)'(TABLE_DEPTH);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MOD, ST_FETCH, ST_READ, ST_DIV, ST_MUL, ST_ADD, ST_OUT
   } state_type;

   state_type   state_ff;
   logic [AW:0] clr_ff;
   logic [31:0] decay_period_ff, exec_inc_ff, write_inc_ff, read_inc_ff;
   logic [15:0] page_ff;
   logic [15:0] red_ff;
   logic [3:0]  step_ff;
   logic [2:0]  kind_ff;
   logic [47:0] now_ff;
   logic [31:0] heat_ff;
   logic [48:0] prod_ff;
   logic [4:0]  shift_ff;
   logic        zero_ff;
   logic [31:0] result_ff;
   logic        valid_ff;

   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   rd_heat, wr_heat;
   logic [47:0]   rd_stamp, wr_stamp, elapsed;
   logic          wr_en;
   logic          div_start, div_done;
   logic          q_big;
   logic [4:0]    q_low;
   logic [7:0]    frac;
   logic [31:0]   divisor, inc;
   logic [32:0]   sum;
   logic [48:0]   cooled;
   logic [39:0]   red_sub;

   // Page index modulo the table size, one conditional subtract per cycle.
   assign red_sub  = 40'(TABLE_DEPTH) << step_ff;

   assign rd_addr  = AW'(red_ff);
   assign elapsed  = (now_ff >= rd_stamp) ? (now_ff - rd_stamp) : 48'd0;
   assign divisor  = (decay_period_ff == 32'd0) ? 32'd1 : decay_period_ff;
   assign div_start = (state_ff == ST_READ);

   phdt_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(elapsed), .divisor(divisor), .done(div_done),
      .q_big(q_big), .q_low(q_low), .frac(frac)
   );

   assign wr_en    = (state_ff == ST_CLEAR) || (state_ff == ST_ADD);
   assign wr_addr  = (state_ff == ST_CLEAR) ? clr_ff[AW-1:0] : AW'(red_ff);
   assign wr_heat  = (state_ff == ST_CLEAR) ? 32'd0 : (sum[32] ? HeatMax : sum[31:0]);
   assign wr_stamp = (state_ff == ST_CLEAR) ? 48'd0 : now_ff;

   phdt_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
      .clock(clock), .rd_addr(rd_addr), .rd_heat(rd_heat), .rd_stamp(rd_stamp),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_heat(wr_heat), .wr_stamp(wr_stamp)
   );

   always_comb begin
      if (kind_ff[2]) begin
         inc = exec_inc_ff;
      end else if (kind_ff[1]) begin
         inc = write_inc_ff;
      end else begin
         inc = read_inc_ff;
      end
   end

   assign cooled = zero_ff ? 49'd0 : (prod_ff >> (6'd16 + 6'(shift_ff)));
   assign sum    = {1'b0, cooled[31:0]} + {1'b0, inc};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         valid_ff        <= 1'b0;
         decay_period_ff <= DecayPeriodReset;
         exec_inc_ff     <= IncReset;
         write_inc_ff    <= IncReset;
         read_inc_ff     <= IncReset;
      end else begin
         valid_ff <= 1'b0;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DECAY_PERIOD: decay_period_ff <= csr_write_data;
               CSR_EXEC_INC:     exec_inc_ff     <= csr_write_data;
               CSR_WRITE_INC:    write_inc_ff    <= csr_write_data;
               CSR_READ_INC:     read_inc_ff     <= csr_write_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == TableDepthW - 1'b1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  page_ff  <= req_page_index;
                  red_ff   <= req_page_index;
                  step_ff  <= 4'd11;
                  kind_ff  <= req_access_kind;
                  now_ff   <= req_now_ms;
                  state_ff <= ST_MOD;
               end
            end
            ST_MOD: begin
               if ({24'd0, red_ff} >= red_sub) begin
                  red_ff <= red_ff - red_sub[15:0];
               end
               step_ff <= step_ff - 4'd1;
               if (step_ff == 4'd0) begin
                  state_ff <= ST_FETCH;
               end
            end
            // The slot is final here; the memories deliver the entry next cycle.
            ST_FETCH: state_ff <= ST_READ;
            ST_READ: begin
               heat_ff  <= rd_heat;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  prod_ff  <= 49'(heat_ff) * 49'(frac_lookup(frac));
                  shift_ff <= q_low;
                  zero_ff  <= q_big;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: state_ff <= ST_ADD;
            ST_ADD: begin
               result_ff <= sum[32] ? HeatMax : sum[31:0];
               valid_ff  <= 1'b1;
               state_ff  <= ST_OUT;
            end
            ST_OUT: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_page_echo = page_ff;
   assign rsp_new_heat  = result_ff;
endmodule

// File: bench/tb_page_hotness_decay_tracker_core.sv
`timescale 1ns / 100ps

module tb_page_hotness_decay_tracker_core;
   import phdt_pkg::*;

   typedef struct packed {
      logic [15:0] page;
      logic [31:0] heat;
   } heat_word_type;

   typedef struct {
      logic [15:0] page;
      logic [2:0]  kind;
      logic [47:0] now;
      bit          typed;
      logic [31:0] heat;
   } sample_row_type;

   localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_page_index = '0;
   logic [2:0]  req_access_kind = '0;
   logic [47:0] req_now_ms = '0;
   logic        rsp_valid;
   logic [15:0] rsp_page_echo;
   logic [31:0] rsp_new_heat;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;

   page_hotness_decay_tracker_core DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   // Mirror of the block's state and registers.
   logic [31:0] decay_period, exec_inc, write_inc, read_inc;
   logic [31:0] heat_mirror [int];
   logic [47:0] stamp_mirror [int];
   logic [16:0] decay_factor [256];
   heat_word_type expected_words [$];
   int          error_count = 0;

   function automatic logic [31:0] heat_after(logic [15:0] page, logic [2:0] kind,
                                              logic [47:0] now);
      logic [63:0] hl, elapsed, q, r, cooled, sum, inc;
      logic [31:0] old_heat;
      logic [47:0] old_stamp;
      int          slot;
      slot = int'(page);
      old_heat = heat_mirror.exists(slot) ? heat_mirror[slot] : 32'd0;
      old_stamp = stamp_mirror.exists(slot) ? stamp_mirror[slot] : 48'd0;
      hl = (decay_period == 0) ? 64'd1 : 64'(decay_period);
      elapsed = (now >= old_stamp) ? 64'(now - old_stamp) : 64'd0;
      q = elapsed / hl;
      r = elapsed % hl;
      if (q >= 32)
         cooled = 0;
      else
         cooled = (64'(old_heat) * 64'(decay_factor[8'((r << 8) / hl)])) >> (16 + q);
      if (kind[2]) inc = 64'(exec_inc);
      else if (kind[1]) inc = 64'(write_inc);
      else inc = 64'(read_inc);
      sum = cooled + inc;
      if (sum > 64'(HeatMax)) sum = 64'(HeatMax);
      heat_mirror[slot] = sum[31:0];
      stamp_mirror[slot] = now;
      return sum[31:0];
   endfunction

   always @(posedge clock) begin
      heat_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word page %h heat %h", $time, rsp_page_echo,
                     rsp_new_heat);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_page_echo !== want.page) begin
               $display("%0t: page_echo expected %h actual %h", $time, want.page,
                        rsp_page_echo);
               error_count++;
            end
            if (rsp_new_heat !== want.heat) begin
               $display("%0t: new_heat expected %h actual %h", $time, want.heat,
                        rsp_new_heat);
               error_count++;
            end
         end
      end
   end

   // Called at a falling edge; returns at a falling edge after the word is taken.
   task automatic send_sample(logic [15:0] page, logic [2:0] kind, logic [47:0] now,
                              bit typed, logic [31:0] typed_heat);
      logic [31:0] predicted;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      repeat (gap) @(negedge clock);
      while (busy) @(negedge clock);
      start = 1'b1;
      req_page_index = page;
      req_access_kind = kind;
      req_now_ms = now;
      predicted = heat_after(page, kind, now);
      expected_words.push_back('{page: page, heat: typed ? typed_heat : predicted});
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic program_regs(logic [31:0] hl, logic [31:0] ex, logic [31:0] wr,
                               logic [31:0] rd);
      logic [31:0] vals [4];
      logic [1:0]  idx  [4];
      vals = '{hl, ex, wr, rd};
      idx = '{CSR_DECAY_PERIOD, CSR_EXEC_INC, CSR_WRITE_INC, CSR_READ_INC};
      while (expected_words.size() != 0) @(negedge clock);
      while (busy) @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_write_enable = 1'b1;
         csr_index = idx[i];
         csr_write_data = vals[i];
         @(negedge clock);
      end
      csr_write_enable = 1'b0;
      decay_period = hl;
      exec_inc = ex;
      write_inc = wr;
      read_inc = rd;
   endtask

   sample_row_type directed [] = '{
      '{16'd5,     3'd1, 48'd0,    1'b1, 32'd65536},
      '{16'd5,     3'd4, 48'd0,    1'b1, 32'd131072},
      '{16'd5,     3'd2, 48'd1000, 1'b1, 32'd131072},
      '{16'd5,     3'd0, 48'd500,  1'b1, 32'd196608},
      '{16'd5,     3'd7, 48'd1700, 1'b0, 32'd0},
      '{16'd5,     3'd3, 48'd1701, 1'b0, 32'd0},
      '{16'd65535, 3'd6, TimeMax,  1'b1, 32'd65536},
      '{16'd65535, 3'd5, 48'd0,    1'b1, 32'd131072},
      '{16'd0,     3'd1, 48'd999,  1'b1, 32'd65536},
      '{16'd0,     3'd1, 48'd33000,1'b0, 32'd0},
      '{16'hAAAA,  3'd2, 48'hAAAA_AAAA_AAAA, 1'b1, 32'd65536},
      '{16'h5555,  3'd4, 48'h5555_5555_5555, 1'b1, 32'd65536},
      '{16'hAAAA,  3'd0, 48'hAAAA_AAAA_AEAA, 1'b0, 32'd0}
   };

   initial begin
      logic [47:0] clock_ms;
      logic [15:0] page;
      logic [47:0] now;
      logic [31:0] hl;
      int          roll;

      decay_factor[0] = 17'd65536;
      begin
         logic [63:0] t;
         t = 64'd1 << 32;
         for (int i = 0; i < 256; i++) begin
            decay_factor[i] = 17'((t + 64'd32768) >> 16);
            t = (t * 64'd4283353945 + (64'd1 << 31)) >> 32;
         end
      end
      decay_period = DecayPeriodReset;
      exec_inc = IncReset;
      write_inc = IncReset;
      read_inc = IncReset;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_sample(directed[i].page, directed[i].kind, directed[i].now,
                     directed[i].typed, directed[i].heat);

      // Saturation, zero half-life and zero increments.
      program_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(16'd5, 3'd4, 48'd1800, 1'b1, 32'hFFFF_FFFF);
      send_sample(16'd5, 3'd1, 48'd1801, 1'b1, 32'hFFFF_FFFF);
      program_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
      send_sample(16'd5, 3'd2, 48'd1802, 1'b0, 32'd0);
      send_sample(16'd5, 3'd0, TimeMax, 1'b0, 32'd0);

      clock_ms = 48'd2000;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: program_regs(32'd1000, 32'd65536, 32'd65536, 32'd65536);
            1: program_regs(32'd1, 32'hFFFF_FFFF, 32'd1, 32'd0);
            2: program_regs(32'hFFFF_FFFF, $urandom, $urandom, $urandom);
            3: program_regs(32'd0, $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                            $urandom_range(0, 1 << 20));
            default: program_regs($urandom_range(1, 5000), $urandom_range(0, 1 << 22),
                                  $urandom_range(0, 1 << 22), $urandom);
         endcase
         hl = (decay_period == 0) ? 32'd1 : decay_period;
         for (int n = 0; n < 180; n++) begin
            roll = $urandom_range(0, 99);
            page = (roll < 85) ? 16'($urandom_range(0, 15)) : 16'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 70)
               clock_ms += 48'($urandom_range(0, 3 * (hl > 4000 ? 4000 : hl)));
            else if (roll < 80)
               clock_ms += 48'($urandom_range(0, 40) * (hl > 100000 ? 100000 : hl));
            if (roll >= 90 && roll < 96)
               now = clock_ms - 48'($urandom_range(1, 3000));
            else if (roll >= 96)
               now = {16'($urandom), 32'($urandom)};
            else
               now = clock_ms;
            send_sample(page, 3'($urandom_range(0, 7)), now, 1'b0, 32'd0);
         end
      end

      while (expected_words.size() != 0) @(negedge clock);
      repeat (70) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: page_hotness_decay_tracker_core.f
src/phdt_pkg.sv
src/phdt_divider.sv
src/phdt_store.sv
src/page_hotness_decay_tracker_core.sv
bench/tb_page_hotness_decay_tracker_core.sv
